### rtl/rhst_pkg.sv
// shared types and constants for the reference-counted handle slot table
package rhst_pkg;

    localparam int NUM_SLOTS = 256;
    localparam int COUNT_W   = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int HW_W      = SLOT_W + 1;
    localparam int OBJ_W     = 32;
    localparam int STATUS_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CONFLICT  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_SATURATED = 3'd5;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ADDREF  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_SET     = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // memory requests from the control unit to both slot memories
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
        logic               cnt_we;
        logic               obj_we;
        logic [SLOT_W-1:0]  wr_addr;
        logic [COUNT_W-1:0] cnt_wdata;
        logic [OBJ_W-1:0]   obj_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   result_slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_after;
        logic                slot_freed;
    } result_t;

endpackage

### rtl/refcounted_handle_slot_table.sv
// top level of the reference-counted handle slot table
// Handle table of NUM_SLOTS slots (slot 0 reserved), each holding a 32-bit object handle
// and a 16-bit word that is the reference count while the slot is live and the next-free
// link while it sits on the free list. Commands: allocate (free-list pop, else grow the
// high-water mark), add reference, release (frees at zero), set object (null handle
// releases). Every command yields exactly one result transaction with a status code.
// Each transaction first reads the slot's word and object from the two synchronous
// memories, then decides and writes back. The block works on one command at a time; the
// finished result sits in an output register, so the next command is taken while the
// result still waits for m_ready. The memories start with undefined contents and need no
// clearing pass: only slots below the high-water mark are ever acted on, and those were
// written on allocation.
module refcounted_handle_slot_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command transaction
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [rhst_pkg::SLOT_W-1:0]     s_slot_id,
    input  logic [rhst_pkg::OBJ_W-1:0]      s_object_handle,
    // result transaction
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rhst_pkg::SLOT_W-1:0]     m_result_slot,
    output logic [rhst_pkg::STATUS_W-1:0]   m_status,
    output logic [rhst_pkg::COUNT_W-1:0]    m_count_after,
    output logic                            m_slot_freed
);
    import rhst_pkg::*;

    mem_req_t           mem_req;
    result_t            res;
    logic               res_valid;
    logic               out_free;
    logic [COUNT_W-1:0] cnt_rd;
    logic [OBJ_W-1:0]   obj_rd;

    // output register state
    logic               out_valid_reg;
    result_t            out_reg;

    // output slot can be loaded when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;

    // count / free-link word per slot
    rhst_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (COUNT_W)
    ) u_count_ram (
        .aclk    (aclk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (cnt_rd),
        .wr_en   (mem_req.cnt_we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.cnt_wdata)
    );

    // object handle per slot
    rhst_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (OBJ_W)
    ) u_object_ram (
        .aclk    (aclk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (obj_rd),
        .wr_en   (mem_req.obj_we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.obj_wdata)
    );

    // sequencer, free-list head and high-water mark
    rhst_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_slot_id       (s_slot_id),
        .s_object_handle (s_object_handle),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res),
        .mem_req         (mem_req),
        .cnt_rd          (cnt_rd),
        .obj_rd          (obj_rd)
    );

    // result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_slot = out_reg.result_slot;
    assign m_status      = out_reg.status;
    assign m_count_after = out_reg.count_after;
    assign m_slot_freed  = out_reg.slot_freed;

    // one command in flight: s_ready is low in the cycle after an accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while previous one still executing");

    // a freed slot always reports ok with a zero count
    a_freed_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_slot_freed) |-> (m_status == STAT_OK && m_count_after == '0))
        else $error("freed slot reported with bad status or count");

    // a failed allocation never reports a slot
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> (m_result_slot == '0))
        else $error("table full result carries a slot id");

    // a result is only produced for a command taken earlier
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("result produced while sequencer idle");

endmodule

### rtl/rhst_ram.sv
// generic single-port-write, single-port-read synchronous ram with registered read
module rhst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rhst_ctrl.sv
// command sequencer: slot read, decision, write back and free-list registers
module rhst_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [rhst_pkg::SLOT_W-1:0]   s_slot_id,
    input  logic [rhst_pkg::OBJ_W-1:0]    s_object_handle,
    input  logic                          out_free,
    output logic                          res_valid,
    output rhst_pkg::result_t             res,
    output rhst_pkg::mem_req_t            mem_req,
    input  logic [rhst_pkg::COUNT_W-1:0]  cnt_rd,
    input  logic [rhst_pkg::OBJ_W-1:0]    obj_rd
);
    import rhst_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [OBJ_W-1:0]    obj_reg;
    logic [SLOT_W-1:0]   free_head_reg, free_head_next;
    logic [HW_W-1:0]     high_water_reg, high_water_next;
    logic                accept;
    logic                exec_fire;

    // decision outputs before gating
    logic                cnt_we_d, obj_we_d;
    logic [SLOT_W-1:0]   wr_addr_d;
    logic [COUNT_W-1:0]  cnt_wdata_d;
    logic [OBJ_W-1:0]    obj_wdata_d;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        exec_fire = (state_reg == ST_EXEC) && out_free;
    end

    assign accept    = s_valid && s_ready;
    assign res_valid = exec_fire;

    // decision on the word and object read back from memory
    always_comb begin
        logic [COUNT_W-1:0] cnt_dec;
        logic               slot_ok;
        logic               do_release;
        logic               link_ok;

        cnt_dec    = cnt_rd - COUNT_W'(1);
        slot_ok    = (slot_reg != '0) && (HW_W'(slot_reg) < high_water_reg);
        do_release = 1'b0;
        link_ok    = 32'(cnt_rd) < 32'(high_water_reg);

        res.result_slot = slot_reg;
        res.status      = STAT_OK;
        res.count_after = '0;
        res.slot_freed  = 1'b0;

        cnt_we_d        = 1'b0;
        obj_we_d        = 1'b0;
        wr_addr_d       = slot_reg;
        cnt_wdata_d     = COUNT_W'(1);
        obj_wdata_d     = obj_reg;
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;

        if (cmd_reg == CMD_ALLOC) begin
            if ((free_head_reg != '0) && (HW_W'(free_head_reg) < high_water_reg)) begin
                // pop the free list; a bad link empties it
                wr_addr_d       = free_head_reg;
                res.result_slot = free_head_reg;
                free_head_next  = link_ok ? cnt_rd[SLOT_W-1:0] : '0;
                cnt_we_d        = 1'b1;
                obj_we_d        = 1'b1;
                res.count_after = COUNT_W'(1);
            end else if (high_water_reg != HW_W'(NUM_SLOTS)) begin
                wr_addr_d       = high_water_reg[SLOT_W-1:0];
                res.result_slot = high_water_reg[SLOT_W-1:0];
                high_water_next = high_water_reg + HW_W'(1);
                cnt_we_d        = 1'b1;
                obj_we_d        = 1'b1;
                res.count_after = COUNT_W'(1);
            end else begin
                res.result_slot = '0;
                res.status      = STAT_FULL;
            end
        end else if (!slot_ok) begin
            res.status = STAT_INVALID;
        end else begin
            unique case (cmd_reg)
                CMD_ADDREF: begin
                    if (cnt_rd == COUNT_MAX) begin
                        res.status      = STAT_SATURATED;
                        res.count_after = cnt_rd;
                    end else begin
                        cnt_we_d        = 1'b1;
                        cnt_wdata_d     = cnt_rd + COUNT_W'(1);
                        res.count_after = cnt_rd + COUNT_W'(1);
                    end
                end
                CMD_RELEASE: do_release = 1'b1;
                CMD_SET: begin
                    if (obj_reg != '0) begin
                        if (obj_rd != '0) begin
                            res.status      = STAT_CONFLICT;
                            res.count_after = cnt_rd;
                        end else begin
                            cnt_we_d        = 1'b1;
                            obj_we_d        = 1'b1;
                            res.count_after = COUNT_W'(1);
                        end
                    end else begin
                        // null handle: clear object only if the count is live
                        obj_we_d    = (cnt_rd != '0);
                        obj_wdata_d = '0;
                        do_release  = 1'b1;
                    end
                end
                default: do_release = 1'b0;
            endcase
        end

        if (do_release) begin
            if (cnt_rd == '0) begin
                res.status = STAT_UNDERFLOW;
            end else if (cnt_dec == '0) begin
                // link onto free list head
                cnt_we_d       = 1'b1;
                cnt_wdata_d    = COUNT_W'(free_head_reg);
                free_head_next = slot_reg;
                res.slot_freed = 1'b1;
            end else begin
                cnt_we_d        = 1'b1;
                cnt_wdata_d     = cnt_dec;
                res.count_after = cnt_dec;
            end
        end
    end

    always_comb begin
        mem_req.rd_en     = accept;
        mem_req.rd_addr   = (cmd_t'(s_command) == CMD_ALLOC) ? free_head_reg : s_slot_id;
        mem_req.cnt_we    = exec_fire && cnt_we_d;
        mem_req.obj_we    = exec_fire && obj_we_d;
        mem_req.wr_addr   = wr_addr_d;
        mem_req.cnt_wdata = cnt_wdata_d;
        mem_req.obj_wdata = obj_wdata_d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            high_water_reg <= HW_W'(1);
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                free_head_reg  <= free_head_next;
                high_water_reg <= high_water_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_command);
            slot_reg <= s_slot_id;
            obj_reg  <= s_object_handle;
        end
    end

endmodule
